@@ sv/tlsd_pkg.sv @@
// ============================================================================
// tlsd_pkg
// Types, codes and defaults shared by the record deframer modules.
// ============================================================================
`timescale 1ns / 1ps

package tlsd_pkg;

    // Fixed widths of the record fields and state.
    localparam int POS_W   = 15;
    localparam int LEN_W   = 16;
    localparam int MAXP_W  = 15;
    localparam int BYTE_W  = 8;

    localparam int HEADER_LEN = 5;

    // Defaults for the module parameters.
    localparam int NONCE_BYTES_DEF     = 12;
    localparam int TAG_BYTES_DEF       = 16;
    localparam int MAX_RECORD_BODY_DEF = 16640;

    // Register reset values.
    localparam logic [BYTE_W-1:0] RECORD_TYPE_RST   = 8'd23;
    localparam logic [BYTE_W-1:0] VERSION_MAJOR_RST = 8'd3;
    localparam logic [BYTE_W-1:0] VERSION_MINOR_RST = 8'd3;
    localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RST   = 15'd16384;

    // APB address and data widths.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_RECORD_TYPE   = 2'd0,
        REG_VERSION_MAJOR = 2'd1,
        REG_VERSION_MINOR = 2'd2,
        REG_MAX_PAYLOAD   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        SEC_HEADER     = 2'd0,
        SEC_NONCE      = 2'd1,
        SEC_CIPHERTEXT = 2'd2,
        SEC_TAG        = 2'd3
    } t_section;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_HDR = 2'd1,
        ST_DROPPED = 2'd2
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] record_type;
        logic [BYTE_W-1:0] version_major;
        logic [BYTE_W-1:0] version_minor;
        logic [MAXP_W-1:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        t_section          section;
        logic              frame_last;
        t_status           status;
    } t_result;

endpackage

@@ sv/tls_record_deframer.sv @@
// ============================================================================
// tls_record_deframer
// An accepted byte is registered in the output buffer before it reaches the outputs.
// Throughput: one byte per cycle while the consumer keeps up; the two-entry output
// buffer takes one more byte into its skid register after the consumer stalls, then holds ready low until it drains.
// Reset (synchronous, active low) returns to the start of a header, reopens the
// stream and loads the register defaults; no clearing pass is needed.
// ============================================================================
`timescale 1ns / 1ps

module tls_record_deframer
    import tlsd_pkg::*;
#(
    parameter int NONCE_BYTES     = NONCE_BYTES_DEF,
    parameter int TAG_BYTES       = TAG_BYTES_DEF,
    parameter int MAX_RECORD_BODY = MAX_RECORD_BODY_DEF
)(
    input  logic              i_clk,
    input  logic              i_rst_n,

    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    // Incoming byte stream.
    input  logic              i_data_valid,
    output logic              o_data_ready,
    input  logic [BYTE_W-1:0] i_data_byte,

    // Tagged byte stream.
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic [1:0]        o_section,
    output logic              o_frame_last,
    output logic [1:0]        o_status
);

    // Each request on the input side is classified in the same cycle it is
    // accepted: the parser looks at the byte together with its position state
    // and produces the section, end-of-record mark and status. The parser state
    // advances at that same edge, and the result is captured by the output
    // buffer, so consecutive bytes can follow each other every cycle while the buffer has room.

    t_cfg    cfg;
    t_result parse_res;
    t_result out_res;
    logic    in_accept;
    logic    stream_closed;

    assign in_accept = i_data_valid && o_data_ready;

    tlsd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The header check runs on the fifth header byte. A failed check marks that
    // byte as an invalid header and closes the stream; from then on every byte
    // is reported as dropped until reset.
    tlsd_parser #(
        .NONCE_BYTES     (NONCE_BYTES),
        .TAG_BYTES       (TAG_BYTES),
        .MAX_RECORD_BODY (MAX_RECORD_BODY)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_cfg       (cfg),
        .o_result    (parse_res),
        .o_closed    (stream_closed)
    );

    // The output buffer decouples the input ready from the consumer's ready,
    // so the input never waits combinationally on the output side.
    tlsd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_data_valid),
        .o_ready (o_data_ready),
        .i_data  (parse_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_res)
    );

    assign o_out_byte   = out_res.out_byte;
    assign o_section    = out_res.section;
    assign o_frame_last = out_res.frame_last;
    assign o_status     = out_res.status;

`ifndef SYNTH
    // Once closed, the stream stays closed until reset.
    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stream_closed |=> stream_closed)
        else $error("stream reopened without reset");

    // The input can only be held off while a result is waiting at the output.
    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_data_ready |-> o_out_valid)
        else $error("input stalled with an empty output stage");

    // The end of a record is always a tag byte of an accepted record.
    a_last_is_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_last) |-> (o_status == ST_OK && o_section == SEC_TAG))
        else $error("frame end outside a tag byte");

    // Dropped and rejected bytes carry no section and no frame end.
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_DROPPED || o_status == ST_BAD_HDR))
            |-> (o_section == SEC_HEADER && !o_frame_last))
        else $error("error byte carries section or frame end");
`endif

endmodule

@@ sv/tlsd_regs.sv @@
// ============================================================================
// tlsd_regs
// APB register bank holding the expected header values and payload limit.
// ============================================================================
`timescale 1ns / 1ps

module tlsd_regs
    import tlsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_RECORD_TYPE:   n_cfg.record_type   = pwdata[BYTE_W-1:0];
                REG_VERSION_MAJOR: n_cfg.version_major = pwdata[BYTE_W-1:0];
                REG_VERSION_MINOR: n_cfg.version_minor = pwdata[BYTE_W-1:0];
                REG_MAX_PAYLOAD:   n_cfg.max_payload   = pwdata[MAXP_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RECORD_TYPE:   prdata = DATA_W'(r_cfg.record_type);
            REG_VERSION_MAJOR: prdata = DATA_W'(r_cfg.version_major);
            REG_VERSION_MINOR: prdata = DATA_W'(r_cfg.version_minor);
            REG_MAX_PAYLOAD:   prdata = DATA_W'(r_cfg.max_payload);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.record_type   <= RECORD_TYPE_RST;
            r_cfg.version_major <= VERSION_MAJOR_RST;
            r_cfg.version_minor <= VERSION_MINOR_RST;
            r_cfg.max_payload   <= MAX_PAYLOAD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/tlsd_parser.sv @@
// ============================================================================
// tlsd_parser
// Record position tracking, header checks and per-byte classification.
// ============================================================================
`timescale 1ns / 1ps

module tlsd_parser
    import tlsd_pkg::*;
#(
    parameter int NONCE_BYTES     = NONCE_BYTES_DEF,
    parameter int TAG_BYTES       = TAG_BYTES_DEF,
    parameter int MAX_RECORD_BODY = MAX_RECORD_BODY_DEF
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  t_cfg              i_cfg,
    output t_result           o_result,
    output logic              o_closed
);

    localparam logic [LEN_W:0]   OVERHEAD = (LEN_W+1)'(NONCE_BYTES + TAG_BYTES);
    localparam logic [LEN_W:0]   MAX_BODY = (LEN_W+1)'(MAX_RECORD_BODY);
    localparam logic [LEN_W-1:0] NONCE_L  = LEN_W'(NONCE_BYTES);
    localparam logic [LEN_W-1:0] TAG_L    = LEN_W'(TAG_BYTES);
    localparam logic [POS_W-1:0] HDR_LAST = POS_W'(HEADER_LEN - 1);

    logic [POS_W-1:0]  r_pos,      n_pos;
    logic              r_mismatch, n_mismatch;
    logic [BYTE_W-1:0] r_len_high, n_len_high;
    logic [LEN_W-1:0]  r_body_len, n_body_len;
    logic              r_closed,   n_closed;

    logic [LEN_W-1:0]  hdr_len;
    logic [LEN_W:0]    len_limit;
    logic [LEN_W-1:0]  pos_ext;
    logic [LEN_W-1:0]  pos_next;
    logic [LEN_W-1:0]  tag_start;
    logic              bad;

    assign hdr_len   = {r_len_high, i_data_byte};
    assign len_limit = (LEN_W+1)'(i_cfg.max_payload) + OVERHEAD;
    assign pos_ext   = LEN_W'(r_pos);
    assign pos_next  = pos_ext + 1'b1;
    assign tag_start = r_body_len - TAG_L;

    always_comb begin
        n_pos      = r_pos;
        n_mismatch = r_mismatch;
        n_len_high = r_len_high;
        n_body_len = r_body_len;
        n_closed   = r_closed;
        bad        = 1'b0;

        o_result.out_byte   = i_data_byte;
        o_result.section    = SEC_HEADER;
        o_result.frame_last = 1'b0;
        o_result.status     = ST_OK;

        if (r_closed) begin
            o_result.status = ST_DROPPED;
        end else if (r_body_len == '0) begin
            case (r_pos)
                POS_W'(0): n_mismatch = (i_data_byte != i_cfg.record_type);
                POS_W'(1): n_mismatch = r_mismatch || (i_data_byte != i_cfg.version_major);
                POS_W'(2): n_mismatch = r_mismatch || (i_data_byte != i_cfg.version_minor);
                POS_W'(3): n_len_high = i_data_byte;
                default:   n_mismatch = r_mismatch;
            endcase
            if (r_pos >= HDR_LAST) begin
                // Fifth header byte: the full length is now known.
                bad = n_mismatch
                    || ({1'b0, hdr_len} < OVERHEAD)
                    || ({1'b0, hdr_len} > len_limit)
                    || ({1'b0, hdr_len} > MAX_BODY);
                n_pos = '0;
                if (bad) begin
                    o_result.status = ST_BAD_HDR;
                    n_closed        = 1'b1;
                end else begin
                    n_body_len = hdr_len;
                end
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end else begin
            if (pos_ext < NONCE_L) begin
                o_result.section = SEC_NONCE;
            end else if (pos_ext >= tag_start) begin
                o_result.section = SEC_TAG;
            end else begin
                o_result.section = SEC_CIPHERTEXT;
            end
            if (pos_next >= r_body_len) begin
                o_result.frame_last = 1'b1;
                n_pos               = '0;
                n_body_len          = '0;
                n_mismatch          = 1'b0;
            end else begin
                n_pos = pos_next[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_mismatch <= 1'b0;
            r_len_high <= '0;
            r_body_len <= '0;
            r_closed   <= 1'b0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_mismatch <= n_mismatch;
            r_len_high <= n_len_high;
            r_body_len <= n_body_len;
            r_closed   <= n_closed;
        end
    end

    assign o_closed = r_closed;

endmodule

@@ sv/tlsd_out_buf.sv @@
// ============================================================================
// tlsd_out_buf
// Two-entry output buffer: result register plus skid register.
// ============================================================================
`timescale 1ns / 1ps

module tlsd_out_buf
    import tlsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;
    logic    in_accept;

    assign o_ready   = !r_skid_valid;
    assign in_accept = i_valid && o_ready;
    assign out_free  = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_accept;
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (in_accept) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

@@ sim/tb_tls_record_deframer.sv @@
// ============================================================================
// tb_tls_record_deframer
// Self-checking bench for the TLS record deframer. A directed record with
// hand-written results comes first. Random records with random bodies
// follow, under several register settings and three stall patterns. The
// run ends with one broken header and the dropped bytes after it. Every
// output byte is compared field by field; past the directed record, against
// a cycle-free model that the bench carries.
// ============================================================================
`timescale 1ns / 1ps

module tb_tls_record_deframer;
    import tlsd_pkg::*;

    // Geometry of the record as built into the instance below.
    localparam int NONCE_B  = NONCE_BYTES_DEF;
    localparam int TAG_B    = TAG_BYTES_DEF;
    localparam int MAX_BODY = MAX_RECORD_BODY_DEF;
    localparam int OVERHEAD = NONCE_B + TAG_B;

    // Stream bytes to send in the random part, split over three stall patterns.
    localparam int RANDOM_BYTES = 1500;
    // Cycles without any accepted request before the run is declared hung.
    localparam int STALL_LIMIT  = 20000;
    // Dropped bytes sent after the stream has been closed.
    localparam int DROP_BYTES   = 40;

    // Ways in which the closing header can be wrong.
    typedef enum logic [2:0] {
        BAD_TYPE,
        BAD_MAJOR,
        BAD_MINOR,
        BAD_SHORT,
        BAD_OVER_PAYLOAD,
        BAD_OVER_RECORD
    } t_bad_hdr;

    // One row of the directed part: a byte, how often it repeats, and the
    // tagging that every copy of it must come back with.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [5:0]        reps;
        t_section          section;
        logic              frame_last;
        t_status           status;
    } t_dir_row;

    // The shortest legal record under the reset registers: header, nonce,
    // no ciphertext, tag. Both byte extremes travel through the body.
    localparam t_dir_row DIR_ROWS [8] = '{
        '{RECORD_TYPE_RST,       6'd1,            SEC_HEADER, 1'b0, ST_OK},
        '{VERSION_MAJOR_RST,     6'd1,            SEC_HEADER, 1'b0, ST_OK},
        '{VERSION_MINOR_RST,     6'd1,            SEC_HEADER, 1'b0, ST_OK},
        '{8'h00,                 6'd1,            SEC_HEADER, 1'b0, ST_OK},
        '{8'(OVERHEAD),          6'd1,            SEC_HEADER, 1'b0, ST_OK},
        '{8'h00,                 6'(NONCE_B),     SEC_NONCE,  1'b0, ST_OK},
        '{8'hFF,                 6'(TAG_B - 1),   SEC_TAG,    1'b0, ST_OK},
        '{8'hFF,                 6'd1,            SEC_TAG,    1'b1, ST_OK}
    };

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_data_valid = 1'b0;
    logic              o_data_ready;
    logic [BYTE_W-1:0] i_data_byte  = '0;
    logic              o_out_valid;
    logic              i_out_ready  = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic [1:0]        o_section;
    logic              o_frame_last;
    logic [1:0]        o_status;

    // The bench's own copy of the registers, mirrored on every write.
    logic [BYTE_W-1:0] cfg_type        = RECORD_TYPE_RST;
    logic [BYTE_W-1:0] cfg_major       = VERSION_MAJOR_RST;
    logic [BYTE_W-1:0] cfg_minor       = VERSION_MINOR_RST;
    logic [MAXP_W-1:0] cfg_max_payload = MAX_PAYLOAD_RST;

    // Deframing state of the model.
    logic [POS_W-1:0]  frame_pos     = '0;
    logic              hdr_bad       = 1'b0;
    logic [BYTE_W-1:0] len_hi        = '0;
    logic [LEN_W-1:0]  rec_len       = '0;
    logic              stream_closed = 1'b0;

    // Tagged bytes the block still owes us, oldest first.
    t_result tagged_bytes_q[$];

    int error_count   = 0;
    int stream_bytes  = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 11;
    int recv_idle_pct = 59;

    tls_record_deframer #(
        .NONCE_BYTES     (NONCE_B),
        .TAG_BYTES       (TAG_B),
        .MAX_RECORD_BODY (MAX_BODY)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_data_valid (i_data_valid),
        .o_data_ready (o_data_ready),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_section    (o_section),
        .o_frame_last (o_frame_last),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Model of the deframer: takes one stream byte, advances the state and
    // returns the tagging that byte must leave the block with.
    function automatic t_result deframe_byte(input logic [BYTE_W-1:0] b);
        t_result     exp_res;
        int unsigned full_len;
        int unsigned off;
        exp_res.out_byte   = b;
        exp_res.section    = SEC_HEADER;
        exp_res.frame_last = 1'b0;
        exp_res.status     = ST_OK;
        if (stream_closed) begin
            // Once a header was rejected, nothing gets through until reset.
            exp_res.status = ST_DROPPED;
        end else if (rec_len == 0) begin
            // Header bytes: type and version are compared as they pass, the
            // length is taken from the last two.
            case (frame_pos)
                15'd0: hdr_bad = (b != cfg_type);
                15'd1: if (b != cfg_major) hdr_bad = 1'b1;
                15'd2: if (b != cfg_minor) hdr_bad = 1'b1;
                15'd3: len_hi = b;
                default: ;
            endcase
            if (frame_pos >= HEADER_LEN - 1) begin
                full_len  = {len_hi, b};
                frame_pos = '0;
                if (hdr_bad || full_len < OVERHEAD
                        || full_len > int'(cfg_max_payload) + OVERHEAD
                        || full_len > MAX_BODY) begin
                    exp_res.status = ST_BAD_HDR;
                    stream_closed  = 1'b1;
                end else begin
                    rec_len = LEN_W'(full_len);
                end
            end else begin
                frame_pos = frame_pos + 1'b1;
            end
        end else begin
            // Body bytes: nonce first, tag last, ciphertext in between.
            off = frame_pos;
            if (off < NONCE_B) begin
                exp_res.section = SEC_NONCE;
            end else if (off >= int'(rec_len) - TAG_B) begin
                exp_res.section = SEC_TAG;
            end else begin
                exp_res.section = SEC_CIPHERTEXT;
            end
            if (off + 1 >= rec_len) begin
                exp_res.frame_last = 1'b1;
                frame_pos = '0;
                rec_len   = '0;
                hdr_bad   = 1'b0;
            end else begin
                frame_pos = POS_W'(off + 1);
            end
        end
        return exp_res;
    endfunction

    // Offers one byte, idling first at the current rate, and waits for the
    // request to be taken. Entered and left right after a rising edge. The
    // expectation is either the model's or, for directed rows, the one given.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
                             input t_result typed_res);
        t_result want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_data_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_data_valid <= 1'b1;
        i_data_byte  <= b;
        do @(posedge i_clk); while (!o_data_ready);
        want = deframe_byte(b);
        if (typed) want = typed_res;
        tagged_bytes_q.push_back(want);
    endtask

    // One well-formed record under the current registers, random body.
    task automatic send_record(input int unsigned len);
        logic [LEN_W-1:0] len16;
        len16 = LEN_W'(len);
        send_byte(cfg_type, 1'b0, '0);
        send_byte(cfg_major, 1'b0, '0);
        send_byte(cfg_minor, 1'b0, '0);
        send_byte(len16[15:8], 1'b0, '0);
        send_byte(len16[7:0], 1'b0, '0);
        repeat (len) send_byte(BYTE_W'($urandom_range(255)), 1'b0, '0);
        stream_bytes += len + HEADER_LEN;
    endtask

    // Holds the sender back until every owed byte has come out. Called right
    // after the last request was taken, so valid drops in that same step.
    task automatic drain_results();
        i_data_valid <= 1'b0;
        while (tagged_bytes_q.size() != 0) @(posedge i_clk);
    endtask

    // Writes one register, then reads it back within the same selection.
    // Bits above the register width carry noise and must be ignored. psel is
    // left high so that back-to-back calls never drive it twice in one step.
    task automatic set_register(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_RECORD_TYPE:   cfg_type        = value[BYTE_W-1:0];
            REG_VERSION_MAJOR: cfg_major       = value[BYTE_W-1:0];
            REG_VERSION_MINOR: cfg_minor       = value[BYTE_W-1:0];
            REG_MAX_PAYLOAD:   cfg_max_payload = value[MAXP_W-1:0];
            default: ;
        endcase
        case (idx)
            REG_RECORD_TYPE:   want = DATA_W'(cfg_type);
            REG_VERSION_MAJOR: want = DATA_W'(cfg_major);
            REG_VERSION_MINOR: want = DATA_W'(cfg_minor);
            default:           want = DATA_W'(cfg_max_payload);
        endcase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("prdata of register %s: expected %0h, got %0h",
                   idx.name(), want, prdata);
            error_count++;
        end
    endtask

    // Loads a full register setting. The first settings hit the byte
    // extremes; the payload limit cycles through zero, the record maximum,
    // tiny values, all ones and anything in range.
    task automatic program_config(input int seg);
        logic [BYTE_W-1:0] rt;
        logic [BYTE_W-1:0] ma;
        logic [BYTE_W-1:0] mi;
        logic [MAXP_W-1:0] mp;
        rt = BYTE_W'($urandom_range(255));
        ma = BYTE_W'($urandom_range(255));
        mi = BYTE_W'($urandom_range(255));
        if (seg == 0) begin
            rt = 8'h00;
            ma = 8'hFF;
            mi = 8'h00;
        end else if (seg == 1) begin
            rt = 8'hFF;
            ma = 8'h00;
            mi = 8'hFF;
        end
        case (seg % 5)
            0: mp = '0;
            1: mp = MAXP_W'(MAX_BODY);
            2: mp = MAXP_W'($urandom_range(40));
            3: mp = '1;
            default: mp = MAXP_W'($urandom_range(MAX_BODY));
        endcase
        set_register(REG_RECORD_TYPE,   ($urandom() & 32'hFFFF_FF00) | DATA_W'(rt));
        set_register(REG_VERSION_MAJOR, ($urandom() & 32'hFFFF_FF00) | DATA_W'(ma));
        set_register(REG_VERSION_MINOR, ($urandom() & 32'hFFFF_FF00) | DATA_W'(mi));
        set_register(REG_MAX_PAYLOAD,   ($urandom() & 32'hFFFF_8000) | DATA_W'(mp));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Body length for a random record: mostly short, often exactly the
    // minimum, and sometimes exactly the limit when the limit is small.
    function automatic int unsigned pick_length();
        int unsigned limit;
        int unsigned roll;
        limit = int'(cfg_max_payload) + OVERHEAD;
        if (limit > MAX_BODY) limit = MAX_BODY;
        roll = $urandom_range(7);
        if (roll == 0) return OVERHEAD;
        if (roll == 1 && limit <= 300) return limit;
        return OVERHEAD + $urandom_range((limit - OVERHEAD > 60) ? 60 : limit - OVERHEAD);
    endfunction

    // Sends one header that must be rejected, then random bytes that must all
    // be dropped. Which rule the header breaks is left to the seed.
    task automatic close_stream();
        t_bad_hdr         kind;
        logic [BYTE_W-1:0] rt;
        logic [BYTE_W-1:0] ma;
        logic [BYTE_W-1:0] mi;
        logic [LEN_W-1:0]  len16;
        kind  = t_bad_hdr'($urandom_range(BAD_OVER_RECORD));
        rt    = cfg_type;
        ma    = cfg_major;
        mi    = cfg_minor;
        len16 = LEN_W'(OVERHEAD);
        case (kind)
            BAD_TYPE:  rt = rt ^ BYTE_W'($urandom_range(1, 255));
            BAD_MAJOR: ma = ma ^ BYTE_W'($urandom_range(1, 255));
            BAD_MINOR: mi = mi ^ BYTE_W'($urandom_range(1, 255));
            BAD_SHORT: len16 = LEN_W'($urandom_range(OVERHEAD - 1));
            BAD_OVER_PAYLOAD:
                len16 = LEN_W'($urandom_range(int'(cfg_max_payload) + OVERHEAD + 1, 65535));
            default:   len16 = LEN_W'($urandom_range(MAX_BODY + 1, 65535));
        endcase
        send_byte(rt, 1'b0, '0);
        send_byte(ma, 1'b0, '0);
        send_byte(mi, 1'b0, '0);
        send_byte(len16[15:8], 1'b0, '0);
        send_byte(len16[7:0], 1'b0, '0);
        repeat (DROP_BYTES) send_byte(BYTE_W'($urandom_range(255)), 1'b0, '0);
    endtask

    // Main sequence: reset, the directed record, then three rounds of random
    // records with the sender and receiver stall rates swapped and finally
    // both off. Registers only change while the block is empty.
    initial begin : stimulus
        int mode_target;
        int seg;
        seg = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[r]) begin
            repeat (DIR_ROWS[r].reps) begin
                send_byte(DIR_ROWS[r].value, 1'b1,
                          t_result'({DIR_ROWS[r].value, DIR_ROWS[r].section,
                                     DIR_ROWS[r].frame_last, DIR_ROWS[r].status}));
            end
        end
        drain_results();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 11 : (mode == 1) ? 59 : 0;
            recv_idle_pct = (mode == 0) ? 59 : (mode == 1) ? 11 : 0;
            mode_target = stream_bytes + RANDOM_BYTES / 3;
            while (stream_bytes < mode_target) begin
                program_config(seg);
                seg++;
                repeat ($urandom_range(2, 6)) send_record(pick_length());
                drain_results();
            end
        end

        // The rejected header closes the stream for good, so it comes last.
        program_config(seg);
        close_stream();
        drain_results();
        repeat (4) @(posedge i_clk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Receiver: checks each byte taken at this edge against the oldest
    // expectation, then decides whether to stall for the next cycle.
    always @(posedge i_clk) begin : out_check
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            got = t_result'({o_out_byte, o_section, o_frame_last, o_status});
            if (tagged_bytes_q.size() == 0) begin
                $error("unexpected output byte %0h with nothing outstanding", o_out_byte);
                error_count++;
            end else begin
                want = tagged_bytes_q.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                    error_count++;
                end
                if (got.section !== want.section) begin
                    $error("section: expected %0d, got %0d", want.section, got.section);
                    error_count++;
                end
                if (got.frame_last !== want.frame_last) begin
                    $error("frame_last: expected %0b, got %0b",
                           want.frame_last, got.frame_last);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any accepted request on either stream or the register port
    // counts as progress. A long stretch without any means the block hung.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_data_valid && o_data_ready) || (o_out_valid && i_out_ready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
